// ===== hdl/assert_macros.svh =====
// -----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers. They compile to nothing in synthesis.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hdl/lccd_pkg.sv =====
// -----------------------------------------------------------------------------
// LRU chunk cache directory package
// Field widths, transfer payload types, sequencer states and defaults.
// -----------------------------------------------------------------------------
`default_nettype none

package lccd_pkg;

    localparam int ENTRIES_DEF       = 512;
    localparam int STAMP_WIDTH_DEF   = 64;
    localparam int DISK_ID_WIDTH_DEF = 4;

    localparam int MODE_W       = 1;
    localparam int IN_DISK_W    = 4;
    localparam int TAG_W        = 52;
    localparam int TARGET_W     = 9;
    localparam int IDX_FIELD_W  = 9;

    localparam logic [MODE_W-1:0] MODE_LOOKUP     = 1'b0;
    localparam logic [MODE_W-1:0] MODE_INVALIDATE = 1'b1;

    typedef struct packed {
        logic [MODE_W-1:0]    mode;
        logic [IN_DISK_W-1:0] disk_id;
        logic [TAG_W-1:0]     chunk_number;
        logic [TARGET_W-1:0]  target_index;
    } t_in_item;

    typedef struct packed {
        logic                   hit;
        logic [IDX_FIELD_W-1:0] entry_index;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

endpackage

`default_nettype wire

// ===== hdl/lru_chunk_cache_directory_unit.sv =====
// -----------------------------------------------------------------------------
// LRU chunk cache directory
// Fully associative tag directory with least-recently-used replacement,
// built around a valid-bit memory and a tag/stamp memory that are scanned
// one entry per cycle.
// -----------------------------------------------------------------------------
//  Channel  | Signals                               | Payload
//  ---------+---------------------------------------+---------------------------
//  in       | i_in_valid, o_in_stall, i_in_data     | mode, disk, tag, target
//  out      | o_out_valid, i_out_stall, o_out_data  | hit, entry_index
//
//  A lookup reads the memories one entry per cycle over a single read port;
//  a hit ends the scan at the matching entry, a miss scans every entry.
//  An invalidate clears the valid bit of an in-range target, gives no result.
//  After reset a clearing pass empties the valid memory; the input is
//  stalled meanwhile. A finished result waits in the output register; the
//  next item is taken while it waits.
// -----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module lru_chunk_cache_directory_unit #(
    parameter int ENTRIES       = lccd_pkg::ENTRIES_DEF,
    parameter int STAMP_WIDTH   = lccd_pkg::STAMP_WIDTH_DEF,
    parameter int DISK_ID_WIDTH = lccd_pkg::DISK_ID_WIDTH_DEF
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_in_valid,
    output logic                     o_in_stall,
    input  wire lccd_pkg::t_in_item  i_in_data,
    output logic                     o_out_valid,
    input  wire                      i_out_stall,
    output lccd_pkg::t_out_item      o_out_data
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int SW    = STAMP_WIDTH;
    localparam int DW    = DISK_ID_WIDTH;
    localparam int TW    = lccd_pkg::TAG_W;
    localparam int PW    = DW + TW + SW;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    // Storage: valid bits in one memory, owner/tag/stamp in the other.
    logic          r_vmem [ENTRIES];
    logic [PW-1:0] r_pmem [ENTRIES];
    logic          r_vq;
    logic [PW-1:0] r_pq;

    logic             vmem_we;
    logic [IDX_W-1:0] vmem_wa;
    logic             vmem_wd;
    logic             pmem_we;
    logic [IDX_W-1:0] pmem_wa;
    logic [PW-1:0]    pmem_wd;

    lccd_pkg::t_state r_state, n_state;
    logic [IDX_W-1:0] r_addr, n_addr;
    logic             r_issue, n_issue;
    logic             r_cmp_vld, n_cmp_vld;
    logic [IDX_W-1:0] r_cmp_idx, n_cmp_idx;
    logic [DW-1:0]    r_disk, n_disk;
    logic [TW-1:0]    r_tag, n_tag;
    logic             r_hit, n_hit;
    logic [IDX_W-1:0] r_sel_idx, n_sel_idx;
    logic             r_vic_have, n_vic_have;
    logic             r_vic_valid, n_vic_valid;
    logic [SW-1:0]    r_vic_stamp, n_vic_stamp;
    logic [IDX_W-1:0] r_vic_idx, n_vic_idx;
    logic [SW-1:0]    r_counter, n_counter;
    logic             r_out_valid, n_out_valid;
    lccd_pkg::t_out_item r_out, n_out;

    logic          in_xfer;
    logic          out_free;
    logic [7:0]    in_disk8;
    logic [DW-1:0] in_disk;
    logic [31:0]   tgt32;
    logic          tgt_ok;
    logic [31:0]   sel32;
    logic [DW-1:0] q_disk;
    logic [TW-1:0] q_tag;
    logic [SW-1:0] q_stamp;
    logic          q_match;
    logic          q_take;
    logic [SW-1:0] next_stamp;

    assign o_in_stall  = (r_state != lccd_pkg::ST_IDLE);
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign in_disk8 = 8'(i_in_data.disk_id);
    assign in_disk  = in_disk8[DW-1:0];
    assign tgt32    = 32'(i_in_data.target_index);
    assign tgt_ok   = (tgt32 < ENTRIES);
    assign sel32    = 32'(r_sel_idx);

    assign q_stamp = r_pq[SW-1:0];
    assign q_tag   = r_pq[SW+TW-1:SW];
    assign q_disk  = r_pq[PW-1:SW+TW];
    assign q_match = r_vq && (q_disk == r_disk) && (q_tag == r_tag);
    // An empty entry always replaces the victim; among full entries the first
    // smallest stamp is kept.
    assign q_take  = !r_vic_have || !r_vq || (r_vic_valid && (q_stamp < r_vic_stamp));
    assign next_stamp = r_counter + SW'(1);

    always_ff @(posedge i_clk) begin
        if (vmem_we) begin
            r_vmem[vmem_wa] <= vmem_wd;
        end
        r_vq <= r_vmem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (pmem_we) begin
            r_pmem[pmem_wa] <= pmem_wd;
        end
        r_pq <= r_pmem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lccd_pkg::ST_CLEAR;
            r_addr      <= '0;
            r_issue     <= 1'b0;
            r_cmp_vld   <= 1'b0;
            r_vic_have  <= 1'b0;
            r_counter   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_issue     <= n_issue;
            r_cmp_vld   <= n_cmp_vld;
            r_vic_have  <= n_vic_have;
            r_counter   <= n_counter;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx   <= n_cmp_idx;
        r_disk      <= n_disk;
        r_tag       <= n_tag;
        r_hit       <= n_hit;
        r_sel_idx   <= n_sel_idx;
        r_vic_valid <= n_vic_valid;
        r_vic_stamp <= n_vic_stamp;
        r_vic_idx   <= n_vic_idx;
        r_out       <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_issue     = r_issue;
        n_cmp_vld   = 1'b0;
        n_cmp_idx   = r_addr;
        n_disk      = r_disk;
        n_tag       = r_tag;
        n_hit       = r_hit;
        n_sel_idx   = r_sel_idx;
        n_vic_have  = r_vic_have;
        n_vic_valid = r_vic_valid;
        n_vic_stamp = r_vic_stamp;
        n_vic_idx   = r_vic_idx;
        n_counter   = r_counter;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;

        vmem_we = 1'b0;
        vmem_wa = r_addr;
        vmem_wd = 1'b0;
        pmem_we = 1'b0;
        pmem_wa = r_sel_idx;
        pmem_wd = {r_disk, r_tag, next_stamp};

        case (r_state)
            lccd_pkg::ST_CLEAR: begin
                vmem_we = 1'b1;
                n_addr  = r_addr + IDX_W'(1);
                if (r_addr == LAST_IDX) begin
                    n_addr  = '0;
                    n_state = lccd_pkg::ST_IDLE;
                end
            end

            lccd_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    if (i_in_data.mode == lccd_pkg::MODE_INVALIDATE) begin
                        vmem_we = tgt_ok;
                        vmem_wa = tgt32[IDX_W-1:0];
                    end else begin
                        n_disk     = in_disk;
                        n_tag      = i_in_data.chunk_number;
                        n_addr     = '0;
                        n_issue    = 1'b1;
                        n_vic_have = 1'b0;
                        n_state    = lccd_pkg::ST_SCAN;
                    end
                end
            end

            lccd_pkg::ST_SCAN: begin
                // One read issued per cycle; its data is compared in the next cycle.
                if (r_issue) begin
                    n_cmp_vld = 1'b1;
                    n_addr    = r_addr + IDX_W'(1);
                    if (r_addr == LAST_IDX) begin
                        n_issue = 1'b0;
                    end
                end
                if (r_cmp_vld) begin
                    if (q_match) begin
                        n_hit     = 1'b1;
                        n_sel_idx = r_cmp_idx;
                        n_issue   = 1'b0;
                        n_cmp_vld = 1'b0;
                        n_state   = lccd_pkg::ST_FINISH;
                    end else begin
                        if (q_take) begin
                            n_vic_have  = 1'b1;
                            n_vic_valid = r_vq;
                            n_vic_stamp = q_stamp;
                            n_vic_idx   = r_cmp_idx;
                        end
                        if (r_cmp_idx == LAST_IDX) begin
                            n_hit     = 1'b0;
                            n_sel_idx = q_take ? r_cmp_idx : r_vic_idx;
                            n_issue   = 1'b0;
                            n_cmp_vld = 1'b0;
                            n_state   = lccd_pkg::ST_FINISH;
                        end
                    end
                end
            end

            lccd_pkg::ST_FINISH: begin
                // The write repeats unchanged while the result waits for a slot.
                vmem_we = 1'b1;
                vmem_wa = r_sel_idx;
                vmem_wd = 1'b1;
                pmem_we = 1'b1;
                if (out_free) begin
                    n_counter         = next_stamp;
                    n_out_valid       = 1'b1;
                    n_out.hit         = r_hit;
                    n_out.entry_index = sel32[lccd_pkg::IDX_FIELD_W-1:0];
                    n_state           = lccd_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = lccd_pkg::ST_IDLE;
            end
        endcase
    end

    `ASSERT_NEXT(a_stamp_step, i_clk, i_rst_n,
        (r_state == lccd_pkg::ST_FINISH) && out_free,
        r_counter == $past(r_counter) + SW'(1))
    `ASSERT_IMPLIES(a_result_source, i_clk, i_rst_n,
        $rose(o_out_valid), $past(r_state) == lccd_pkg::ST_FINISH)
    `ASSERT_IMPLIES(a_no_stray_read, i_clk, i_rst_n,
        r_state != lccd_pkg::ST_SCAN, !r_issue && !r_cmp_vld)
    `ASSERT_IMPLIES(a_finish_cover, i_clk, i_rst_n,
        (r_state == lccd_pkg::ST_FINISH) && !r_hit, r_vic_have)

endmodule

`default_nettype wire

// ===== verif/lru_directory_checker.sv =====
// ----------------------------------------------------------------------------
// LRU chunk directory checker
// Watches both channels of the directory, keeps its own copy of the tags,
// valid bits and use stamps, predicts the reply to every lookup transfer and
// compares each reply transfer with the oldest reply still awaited.
// ----------------------------------------------------------------------------
module lru_directory_checker #(
    parameter int ENTRIES       = lccd_pkg::ENTRIES_DEF,
    parameter int STAMP_WIDTH   = lccd_pkg::STAMP_WIDTH_DEF,
    parameter int DISK_ID_WIDTH = lccd_pkg::DISK_ID_WIDTH_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    input  wire                 i_in_stall,
    input  lccd_pkg::t_in_item  i_in_data,
    input  wire                 i_out_valid,
    input  wire                 i_out_stall,
    input  lccd_pkg::t_out_item i_out_data,
    output int                  o_fail_count,
    output int                  o_outstanding
);

    logic                       entry_valid [ENTRIES];
    logic [DISK_ID_WIDTH-1:0]   entry_disk  [ENTRIES];
    logic [lccd_pkg::TAG_W-1:0] entry_tag   [ENTRIES];
    logic [STAMP_WIDTH-1:0]     entry_stamp [ENTRIES];
    logic [STAMP_WIDTH-1:0]     use_count;
    lccd_pkg::t_out_item        awaited_replies[$];
    int                         mismatches = 0;

    initial begin
        o_fail_count  = 0;
        o_outstanding = 0;
    end

    // Searches the directory for the chunk, refreshes its stamp on a hit and
    // installs it in the chosen victim on a miss.
    function automatic lccd_pkg::t_out_item resolve_lookup(
            input logic [DISK_ID_WIDTH-1:0] disk,
            input logic [lccd_pkg::TAG_W-1:0] tag);
        lccd_pkg::t_out_item reply;
        int                  victim;
        victim = 0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (entry_valid[i] && entry_disk[i] == disk && entry_tag[i] == tag) begin
                use_count      = use_count + 1'b1;
                entry_stamp[i] = use_count;
                reply.hit         = 1'b1;
                reply.entry_index = lccd_pkg::IDX_FIELD_W'(i);
                return reply;
            end
            // An empty entry always wins, so the last empty one is kept;
            // among full entries only a strictly older stamp replaces.
            if (!entry_valid[i] ||
                (entry_valid[victim] && entry_stamp[i] < entry_stamp[victim])) begin
                victim = i;
            end
        end
        use_count           = use_count + 1'b1;
        entry_valid[victim] = 1'b1;
        entry_disk[victim]  = disk;
        entry_tag[victim]   = tag;
        entry_stamp[victim] = use_count;
        reply.hit         = 1'b0;
        reply.entry_index = lccd_pkg::IDX_FIELD_W'(victim);
        return reply;
    endfunction

    always @(posedge i_clk) begin
        lccd_pkg::t_out_item want;
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                entry_valid[i] = 1'b0;
            end
            use_count = '0;
            awaited_replies.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (awaited_replies.size() == 0) begin
                    $error("reply transfer with no lookup awaiting it: hit=%0d entry_index=%0d",
                           i_out_data.hit, i_out_data.entry_index);
                    mismatches++;
                end else begin
                    want = awaited_replies.pop_front();
                    if (i_out_data.hit !== want.hit) begin
                        $error("hit mismatch: expected %0d, actual %0d",
                               want.hit, i_out_data.hit);
                        mismatches++;
                    end
                    if (i_out_data.entry_index !== want.entry_index) begin
                        $error("entry_index mismatch: expected %0d, actual %0d",
                               want.entry_index, i_out_data.entry_index);
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_in_data.mode == lccd_pkg::MODE_INVALIDATE) begin
                    if (int'(i_in_data.target_index) < ENTRIES) begin
                        entry_valid[i_in_data.target_index] = 1'b0;
                    end
                end else begin
                    awaited_replies.push_back(resolve_lookup(
                        DISK_ID_WIDTH'(i_in_data.disk_id), i_in_data.chunk_number));
                end
            end
        end
        o_fail_count  <= mismatches;
        o_outstanding <= awaited_replies.size();
    end

endmodule

// ===== verif/lru_chunk_cache_directory_unit_tb.sv =====
// ----------------------------------------------------------------------------
// LRU chunk cache directory testbench
// Drives directed and random lookup and invalidate transfers into the
// directory with random idling on both channels, one long reply hold-off and
// repeated full drains, and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module lru_chunk_cache_directory_unit_tb;

    localparam int ENTRIES         = lccd_pkg::ENTRIES_DEF;
    localparam int RANDOM_ITEMS    = 1080;
    localparam int HOLD_OFF_AFTER  = 300;
    localparam int HOLD_OFF_CYCLES = 3000;
    localparam int DRAIN_CYCLES    = ENTRIES + 16;

    localparam logic [lccd_pkg::TAG_W-1:0] TAG_MAX = '1;
    localparam logic [lccd_pkg::TAG_W-1:0] TAG_ODD = 52'hAAAAAAAAAAAAA;
    localparam logic [lccd_pkg::TAG_W-1:0] TAG_EVN = 52'h5555555555555;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_stall;
    lccd_pkg::t_in_item  in_data   = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    lccd_pkg::t_out_item out_data;

    int fail_count;
    int outstanding;
    int results_taken = 0;

    logic [lccd_pkg::IN_DISK_W+lccd_pkg::TAG_W-1:0] chunk_history[$];

    always #5 clk = ~clk;

    lru_chunk_cache_directory_unit i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    lru_directory_checker i_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_in_data     (in_data),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_out_data    (out_data),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            results_taken <= results_taken + 1;
        end
    end

    function automatic logic [lccd_pkg::TAG_W-1:0] random_chunk();
        logic [63:0] wide;
        wide = {$urandom(), $urandom()};
        return wide[lccd_pkg::TAG_W-1:0];
    endfunction

    function automatic lccd_pkg::t_in_item random_item();
        lccd_pkg::t_in_item item;
        item.mode         = lccd_pkg::MODE_W'($urandom_range(1));
        item.disk_id      = lccd_pkg::IN_DISK_W'($urandom());
        item.chunk_number = random_chunk();
        item.target_index = lccd_pkg::TARGET_W'($urandom());
        return item;
    endfunction

    function automatic lccd_pkg::t_in_item make_item(
            input logic [lccd_pkg::MODE_W-1:0]    mode,
            input logic [lccd_pkg::IN_DISK_W-1:0] disk,
            input logic [lccd_pkg::TAG_W-1:0]     chunk,
            input logic [lccd_pkg::TARGET_W-1:0]  target);
        lccd_pkg::t_in_item item;
        item.mode         = mode;
        item.disk_id      = disk;
        item.chunk_number = chunk;
        item.target_index = target;
        return item;
    endfunction

    // Mostly back to back, often a few cycles, now and then a long pause.
    function automatic int sender_gap();
        int r;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(3, 1);
        return $urandom_range(60, 15);
    endfunction

    task automatic send_item(input lccd_pkg::t_in_item item);
        int gap;
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (item.mode == lccd_pkg::MODE_LOOKUP) begin
            chunk_history.push_back({item.disk_id, item.chunk_number});
        end
        gap = sender_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            in_data  <= random_item();
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    // Reply side: free stretches and stalls of random length, plus one long
    // hold-off once enough replies have gone through.
    initial begin
        bit hold_done;
        int r;
        hold_done = 1'b0;
        forever begin
            if (!hold_done && results_taken >= HOLD_OFF_AFTER) begin
                hold_done = 1'b1;
                out_stall <= 1'b1;
                for (int c = 0; c < HOLD_OFF_CYCLES; c++) @(posedge clk);
            end
            r = $urandom_range(99);
            out_stall <= 1'b0;
            if (r < 10) repeat ($urandom_range(1500, 300)) @(posedge clk);
            else repeat ($urandom_range(30, 1)) @(posedge clk);
            r = $urandom_range(99);
            out_stall <= 1'b1;
            if (r < 85) repeat ($urandom_range(4, 1)) @(posedge clk);
            else repeat ($urandom_range(120, 20)) @(posedge clk);
        end
    end

    initial begin
        lccd_pkg::t_in_item item;
        int                 r;
        int                 span;
        int                 pick;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Entries fill from the top index down while empty ones remain.
        send_item(make_item(lccd_pkg::MODE_LOOKUP, 4'h0, '0, '0));
        send_item(make_item(lccd_pkg::MODE_LOOKUP, 4'hF, TAG_MAX, '1));
        send_item(make_item(lccd_pkg::MODE_LOOKUP, 4'h0, '0, '1));
        send_item(make_item(lccd_pkg::MODE_LOOKUP, 4'hF, '0, '0));
        send_item(make_item(lccd_pkg::MODE_LOOKUP, 4'h0, TAG_MAX, '0));
        send_item(make_item(lccd_pkg::MODE_LOOKUP, 4'hA, TAG_ODD, 9'h155));
        send_item(make_item(lccd_pkg::MODE_LOOKUP, 4'h5, TAG_EVN, 9'h0AA));
        // Invalidate of an empty entry, with lookup fields that must be ignored.
        send_item(make_item(lccd_pkg::MODE_INVALIDATE, 4'hF, TAG_MAX, '0));
        send_item(make_item(lccd_pkg::MODE_INVALIDATE, 4'h0, '0, '1));
        send_item(make_item(lccd_pkg::MODE_LOOKUP, 4'h0, '0, '0));
        send_item(make_item(lccd_pkg::MODE_INVALIDATE, 4'h0, '0, 9'd510));
        send_item(make_item(lccd_pkg::MODE_INVALIDATE, 4'h0, '0, 9'd510));
        send_item(make_item(lccd_pkg::MODE_INVALIDATE, 4'hA, TAG_ODD, 9'd509));
        send_item(make_item(lccd_pkg::MODE_LOOKUP, 4'hF, TAG_MAX, '0));
        send_item(make_item(lccd_pkg::MODE_LOOKUP, 4'hF, '0, '0));
        send_item(make_item(lccd_pkg::MODE_LOOKUP, 4'hA, TAG_ODD, '0));
        send_item(make_item(lccd_pkg::MODE_LOOKUP, 4'h5, TAG_EVN, '1));
        send_item(make_item(lccd_pkg::MODE_LOOKUP, 4'h0, TAG_MAX, '1));
        send_item(make_item(lccd_pkg::MODE_LOOKUP, 4'h5, TAG_ODD, '0));
        send_item(make_item(lccd_pkg::MODE_LOOKUP, 4'hA, TAG_EVN, '1));
        drain_results();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 2) drain_results();
            item = random_item();
            r = $urandom_range(99);
            if (r < 7) begin
                item.mode = lccd_pkg::MODE_INVALIDATE;
                if ($urandom_range(1) == 1) begin
                    item.target_index =
                        lccd_pkg::TARGET_W'($urandom_range(ENTRIES - 1, ENTRIES - 64));
                end
            end else begin
                item.mode = lccd_pkg::MODE_LOOKUP;
                if (r < 10) begin
                    item.chunk_number = ($urandom_range(1) == 1) ? TAG_MAX : '0;
                end else if (r >= 72 && chunk_history.size() > 0) begin
                    // Recent chunks are likely hits, old ones may have been evicted.
                    span = (r < 90 && chunk_history.size() > 48) ? 48 : chunk_history.size();
                    pick = chunk_history.size() - 1 - $urandom_range(span - 1);
                    {item.disk_id, item.chunk_number} = chunk_history[pick];
                    if (r >= 96) begin
                        item.disk_id = item.disk_id ^
                                       lccd_pkg::IN_DISK_W'($urandom_range(15, 1));
                    end
                end
            end
            send_item(item);
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("PASS lru_chunk_cache_directory_unit");
        end else begin
            $display("FAIL lru_chunk_cache_directory_unit");
        end
        $finish;
    end

    initial begin
        #50000000;
        $display("FAIL lru_chunk_cache_directory_unit");
        $finish;
    end

endmodule
